// ===== rtl/sic_pkg.sv =====
// Shared types and constants for the segment intersection classifier.
// No dependencies; imported by the top level and the testbench.
`default_nettype none
package sic_pkg;
  typedef enum logic [1:0] {
    REL_NONE     = 2'd0,
    REL_CROSS    = 2'd1,
    REL_TOUCH    = 2'd2,
    REL_COINCIDE = 2'd3
  } rel_t;
  localparam int ALPHA_BITS = 17;
endpackage
`default_nettype wire

// ===== rtl/sic_div_stage.sv =====
// One restoring step of the pipelined fraction divider, with a stall-aware register.
// Depends on nothing beyond its parameters.
`default_nettype none
module sic_div_stage #(
  parameter int RW    = 68,
  parameter int QW    = 17,
  parameter bit SHIFT = 1'b1
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [RW-1:0] r_in,
  input  wire logic [RW-1:0] d_in,
  input  wire logic [QW-1:0] q_in,
  output logic      [RW-1:0] r_out,
  output logic      [RW-1:0] d_out,
  output logic      [QW-1:0] q_out
);
  // The integer step compares the numerator as it stands; every later step
  // doubles the remainder first.
  logic [RW:0] sh;
  logic [RW:0] diff;
  always_comb begin
    sh   = SHIFT ? {r_in, 1'b0} : {1'b0, r_in};
    diff = sh - {1'b0, d_in};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (!diff[RW]) begin
        r_out <= diff[RW-1:0];
        q_out <= {q_in[QW-2:0], 1'b1};
      end else begin
        r_out <= sh[RW-1:0];
        q_out <= {q_in[QW-2:0], 1'b0};
      end
      d_out <= d_in;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/segment_intersection_classifier.sv =====
// Segment intersection classifier, top level.
// Throughput: one item per cycle; the whole pipeline advances when not stalled,
// with a single output register holding the result while stall is high.
// Reset (synchronous, rst) clears every valid bit; payload registers are not reset.
// Depends on sic_pkg and sic_div_stage.
`default_nettype none
module segment_intersection_classifier
  import sic_pkg::*;
#(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [COORD_BITS-1:0] p1_x,
  input  wire logic [COORD_BITS-1:0] p1_y,
  input  wire logic [COORD_BITS-1:0] p2_x,
  input  wire logic [COORD_BITS-1:0] p2_y,
  input  wire logic [COORD_BITS-1:0] q1_x,
  input  wire logic [COORD_BITS-1:0] q1_y,
  input  wire logic [COORD_BITS-1:0] q2_x,
  input  wire logic [COORD_BITS-1:0] q2_y,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 relation,
  output logic [ALPHA_BITS-1:0]      alpha_p,
  output logic [ALPHA_BITS-1:0]      alpha_q
);
  // Differences need one more bit, products twice that, and the edge
  // coordinate one more again. Divisor |WP1-WP2| needs a further bit.
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int EW = PW + 1;
  localparam int RW = EW + 2;
  localparam int QW = FRAC_BITS + 2;
  localparam int NS = FRAC_BITS + 1;
  localparam int VL = NS + 4;

  // The pipeline moves as one; it is frozen only while a held result waits.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic [VL-1:0] vld;

  // Stage 1: differences and bounding-box rejection.
  logic signed [DW-1:0] a_ux, a_uy, a_vx, a_vy;
  logic signed [DW-1:0] a_p1x, a_p1y, a_p2x, a_p2y;
  logic signed [DW-1:0] a_q1x, a_q1y, a_q2x, a_q2y;
  logic                 a_rej;
  logic signed [COORD_BITS-1:0] sp1x, sp1y, sp2x, sp2y, sq1x, sq1y, sq2x, sq2y;
  logic signed [COORD_BITS-1:0] lft, rgt, bot, top;
  always_comb begin
    sp1x = p1_x; sp1y = p1_y; sp2x = p2_x; sp2y = p2_y;
    sq1x = q1_x; sq1y = q1_y; sq2x = q2_x; sq2y = q2_y;
    lft = (sq1x < sq2x) ? sq1x : sq2x;
    rgt = (sq1x < sq2x) ? sq2x : sq1x;
    bot = (sq1y < sq2y) ? sq1y : sq2y;
    top = (sq1y < sq2y) ? sq2y : sq1y;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a_ux  <= DW'(sq2x) - DW'(sq1x);
      a_uy  <= DW'(sq2y) - DW'(sq1y);
      a_vx  <= DW'(sp2x) - DW'(sp1x);
      a_vy  <= DW'(sp2y) - DW'(sp1y);
      a_p1x <= DW'(sp1x) - DW'(sq1x);
      a_p1y <= DW'(sp1y) - DW'(sq1y);
      a_p2x <= DW'(sp2x) - DW'(sq1x);
      a_p2y <= DW'(sp2y) - DW'(sq1y);
      a_q1x <= DW'(sq1x) - DW'(sp1x);
      a_q1y <= DW'(sq1y) - DW'(sp1y);
      a_q2x <= DW'(sq2x) - DW'(sp1x);
      a_q2y <= DW'(sq2y) - DW'(sp1y);
      a_rej <= (sp1x < lft && sp2x < lft) || (sp1x > rgt && sp2x > rgt) ||
               (sp1y < bot && sp2y < bot) || (sp1y > top && sp2y > top);
    end
  end

  // Stage 2: the eight products, one multiplier each.
  logic signed [PW-1:0] m_p1a, m_p1b, m_p2a, m_p2b, m_q1a, m_q1b, m_q2a, m_q2b;
  logic                 m_rej;
  always_ff @(posedge clk) begin
    if (adv) begin
      m_p1a <= a_p1y * a_ux;  m_p1b <= a_p1x * a_uy;
      m_p2a <= a_p2y * a_ux;  m_p2b <= a_p2x * a_uy;
      m_q1a <= a_q1y * a_vx;  m_q1b <= a_q1x * a_vy;
      m_q2a <= a_q2y * a_vx;  m_q2b <= a_q2x * a_vy;
      m_rej <= a_rej;
    end
  end

  // Stage 3: edge coordinates.
  logic signed [EW-1:0] wp1, wp2, wq1, wq2;
  logic                 w_rej;
  always_ff @(posedge clk) begin
    if (adv) begin
      wp1 <= EW'(m_p1a) - EW'(m_p1b);
      wp2 <= EW'(m_p2a) - EW'(m_p2b);
      wq1 <= EW'(m_q1a) - EW'(m_q1b);
      wq2 <= EW'(m_q2a) - EW'(m_q2b);
      w_rej <= m_rej;
    end
  end

  // Stage 4: classification and divider set-up. The sign of the divisor
  // is folded into the numerator so the divisor is non-negative.
  logic                 same_p, same_q, coll, open0, touch;
  logic [1:0]           c_rel;
  logic signed [RW-1:0] dp, dq, np, nq;
  always_comb begin
    same_p = (wp1 != '0) && (wp2 != '0) && (wp1[EW-1] == wp2[EW-1]);
    same_q = (wq1 != '0) && (wq2 != '0) && (wq1[EW-1] == wq2[EW-1]);
    coll   = (wp1 == wp2) || (wq1 == wq2);
    open0  = (wp1 == '0) || (wq1 == '0);
    touch  = (wp2 == '0) || (wq2 == '0);
    priority if (w_rej || same_p || same_q) c_rel = REL_NONE;
    else if (coll)  c_rel = REL_COINCIDE;
    else if (open0) c_rel = REL_NONE;
    else if (touch) c_rel = REL_TOUCH;
    else            c_rel = REL_CROSS;
    dp = RW'(wp1) - RW'(wp2);
    dq = RW'(wq1) - RW'(wq2);
    np = RW'(wp1);
    nq = RW'(wq1);
    if (dp[RW-1]) begin dp = -dp; np = -np; end
    if (dq[RW-1]) begin dq = -dq; nq = -nq; end
  end

  logic [RW-1:0] rp [NS+1];
  logic [RW-1:0] rq [NS+1];
  logic [RW-1:0] ddp [NS+1];
  logic [RW-1:0] ddq [NS+1];
  logic [QW-1:0] qp [NS+1];
  logic [QW-1:0] qq [NS+1];
  logic [1:0]    rl [NS+1];

  // The relation rides alongside the divider steps.
  always_ff @(posedge clk) begin
    if (adv) begin
      rl[0]  <= c_rel;
      ddp[0] <= dp;
      ddq[0] <= dq;
      qp[0]  <= '0;
      qq[0]  <= '0;
      // A numerator made negative means a zero alpha; a zero remainder gives it.
      rp[0]  <= np[RW-1] ? '0 : np;
      rq[0]  <= nq[RW-1] ? '0 : nq;
      for (int i = 0; i < NS; i++) begin
        rl[i+1] <= rl[i];
      end
    end
  end

  // The first step of the divider takes the integer bit (ratio may be one),
  // so it compares without doubling the remainder.
  genvar g;
  generate
    for (g = 0; g < NS; g++) begin : g_div
      sic_div_stage #(.RW(RW), .QW(QW), .SHIFT(g != 0)) u_p (
        .clk(clk), .en(adv), .r_in(rp[g]), .d_in(ddp[g]), .q_in(qp[g]),
        .r_out(rp[g+1]), .d_out(ddp[g+1]), .q_out(qp[g+1]));
      sic_div_stage #(.RW(RW), .QW(QW), .SHIFT(g != 0)) u_q (
        .clk(clk), .en(adv), .r_in(rq[g]), .d_in(ddq[g]), .q_in(qq[g]),
        .r_out(rq[g+1]), .d_out(ddq[g+1]), .q_out(qq[g+1]));
    end
  endgenerate

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[VL-2:0], in_valid};
    end
  end

  // Output register.
  logic show;
  assign show = (rl[NS] == REL_CROSS) || (rl[NS] == REL_TOUCH);
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[VL-1];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      relation <= rl[NS];
      alpha_p  <= show ? ALPHA_BITS'(qp[NS]) : '0;
      alpha_q  <= show ? ALPHA_BITS'(qq[NS]) : '0;
    end
  end
endmodule
`default_nettype wire

// ===== tb/tb_segment_intersection_classifier.sv =====
// Self-checking testbench for segment_intersection_classifier.
// Predicts relation and alpha fields for each accepted segment pair and checks
// the results in order. Depends on sic_pkg and the block's RTL.
`default_nettype none

// Holds the expected relation and alphas of pairs that are still in flight.
class segment_verdict_board;
  typedef struct {
    sic_pkg::rel_t   rel;
    logic [16:0]     ap;
    logic [16:0]     aq;
  } verdict_t;

  verdict_t pending[$];
  int       fails;

  // Cross product (ay-by)*(cx-dx) - (ax-bx)*(cy-dy); fits easily in 128 bits.
  static function logic signed [127:0] edge_coord(longint ax, longint ay, longint bx,
                                                  longint by, longint cx, longint cy,
                                                  longint dx, longint dy);
    logic signed [127:0] t1, t2;
    t1 = 128'(ay - by) * 128'(cx - dx);
    t2 = 128'(ax - bx) * 128'(cy - dy);
    return t1 - t2;
  endfunction

  static function bit apart(logic signed [127:0] a, logic signed [127:0] b);
    if (a == 0 || b == 0) return 1;
    return a[127] != b[127];
  endfunction

  // Truncated n/(n-m) with 16 fraction bits, done by restoring division.
  static function logic [16:0] ratio(logic signed [127:0] n, logic signed [127:0] m);
    logic signed [127:0] d, r;
    logic [63:0]         q;
    d = n - m;
    q = 0;
    if (d < 0) begin
      d = -d;
      n = -n;
    end
    r = n;
    if (r < 0) return 0;
    if (r >= d) begin
      q = 1;
      r = r - d;
    end
    for (int i = 0; i < 16; i++) begin
      r = r <<< 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return q[16:0];
  endfunction

  function void note_pair(logic signed [23:0] c[8]);
    verdict_t            v;
    longint              p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y, lft, rgt, bot, top;
    logic signed [127:0] wp1, wp2, wq1, wq2;
    p1x = c[0]; p1y = c[1]; p2x = c[2]; p2y = c[3];
    q1x = c[4]; q1y = c[5]; q2x = c[6]; q2y = c[7];
    lft = q1x < q2x ? q1x : q2x; rgt = q1x < q2x ? q2x : q1x;
    bot = q1y < q2y ? q1y : q2y; top = q1y < q2y ? q2y : q1y;
    v.rel = sic_pkg::REL_NONE;
    v.ap = 0;
    v.aq = 0;
    wp1 = edge_coord(p1x, p1y, q1x, q1y, q2x, q2y, q1x, q1y);
    wp2 = edge_coord(p2x, p2y, q1x, q1y, q2x, q2y, q1x, q1y);
    wq1 = edge_coord(q1x, q1y, p1x, p1y, p2x, p2y, p1x, p1y);
    wq2 = edge_coord(q2x, q2y, p1x, p1y, p2x, p2y, p1x, p1y);
    if ((p1x < lft && p2x < lft) || (p1x > rgt && p2x > rgt) ||
        (p1y < bot && p2y < bot) || (p1y > top && p2y > top)) begin
      // Both P ends beyond one side of Q's box.
    end else if (!apart(wp1, wp2) || !apart(wq1, wq2)) begin
      // One segment lies wholly on one side of the other's line.
    end else if (wp1 == wp2 || wq1 == wq2) begin
      v.rel = sic_pkg::REL_COINCIDE;
    end else if (wp1 != 0 && wq1 != 0) begin
      v.ap = ratio(wp1, wp2);
      v.aq = ratio(wq1, wq2);
      v.rel = (wp2 == 0 || wq2 == 0) ? sic_pkg::REL_TOUCH : sic_pkg::REL_CROSS;
    end
    pending.push_back(v);
  endfunction

  function void check_result(logic [1:0] rel, logic [16:0] ap, logic [16:0] aq);
    verdict_t v;
    if (pending.size() == 0) begin
      $error("unexpected result: relation %0d", rel);
      fails++;
      return;
    end
    v = pending.pop_front();
    if (rel !== v.rel) begin
      $error("relation: expected %0d, got %0d", v.rel, rel);
      fails++;
    end
    if (ap !== v.ap) begin
      $error("alpha_p: expected %0d, got %0d", v.ap, ap);
      fails++;
    end
    if (aq !== v.aq) begin
      $error("alpha_q: expected %0d, got %0d", v.aq, aq);
      fails++;
    end
  endfunction
endclass

module tb_segment_intersection_classifier;
  import sic_pkg::*;

  // The drain wait covers the latency of the block.
  localparam int LATENCY    = 21;
  localparam int RAND_ITEMS = 530;
  localparam int LIMIT      = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        out_stall = 1'b0;
  logic [23:0] p1_x = '0, p1_y = '0, p2_x = '0, p2_y = '0;
  logic [23:0] q1_x = '0, q1_y = '0, q2_x = '0, q2_y = '0;
  logic        in_stall, out_valid;
  logic [1:0]  relation;
  logic [16:0] alpha_p, alpha_q;

  segment_verdict_board board = new();
  int  cycles = 0;
  bit  calm = 1'b0;   // set in the final stretch: no idling on either side

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  segment_intersection_classifier dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .p1_x(p1_x), .p1_y(p1_y), .p2_x(p2_x), .p2_y(p2_y),
    .q1_x(q1_x), .q1_y(q1_y), .q2_x(q2_x), .q2_y(q2_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .relation(relation), .alpha_p(alpha_p), .alpha_q(alpha_q)
  );

  // Results are sampled at the rising edge, where the handshake completes.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) board.check_result(relation, alpha_p, alpha_q);
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The receiver stalls in random bursts, changing at the falling edge so
  // that the block sees a settled value.
  initial begin
    int n;
    @(negedge clk);
    while (!rst) @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n = $urandom_range(1, 8);
      out_stall <= (!calm && $urandom_range(0, 3) == 0);
      repeat (n) @(negedge clk);
    end
  end

  // Drives one pair and holds it until the block accepts it. The pair is
  // predicted as it is accepted, so the expected results keep input order.
  task automatic send_pair(logic signed [23:0] c[8]);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    {p1_x, p1_y, p2_x, p2_y} <= {c[0], c[1], c[2], c[3]};
    {q1_x, q1_y, q2_x, q2_y} <= {c[4], c[5], c[6], c[7]};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_pair(c);
    @(negedge clk);
  endtask

  function automatic logic signed [23:0] rnd_coord(int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 40)) - 20);
      default: return 24'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  initial begin
    logic signed [23:0] c[8];
    int mode, kind;
    logic signed [23:0] k;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed pairs: plain cross, touch at P2, open start at P1, collinear,
    // degenerate P on Q's line, box rejection, same-side rejection, extremes.
    c = '{-10, 0, 10, 0, 0, -10, 0, 10};       send_pair(c);
    c = '{-10, 0, 0, 0, 0, -10, 0, 10};        send_pair(c);
    c = '{0, 0, 10, 0, 0, -10, 0, 10};         send_pair(c);
    c = '{-10, 0, 10, 5, 0, -10, 0, 0};        send_pair(c);
    c = '{0, 0, 10, 0, 5, 0, 20, 0};           send_pair(c);
    c = '{3, 3, 3, 3, 0, 0, 10, 10};           send_pair(c);
    c = '{-20, 0, -15, 5, 0, 0, 10, 10};       send_pair(c);
    c = '{0, 20, 10, 20, 0, 0, 10, 10};        send_pair(c);
    c = '{0, 1, 10, 2, 0, 0, 10, 10};          send_pair(c);
    c = '{-10, 0, 10, 1, 0, -1000, 0, 1000};   send_pair(c);
    c = '{-8388608, -8388608, 8388607, 8388607, -8388608, 8388607, 8388607, -8388608};
    send_pair(c);
    c = '{8388607, -8388608, -8388608, 8388607, -8388608, -8388608, 8388607, 8388607};
    send_pair(c);
    c = '{-8388608, 0, 8388607, 1, 0, -8388608, 1, 8388607};
    send_pair(c);
    c = '{-1, -1, 1, 1, 1, 1, 5, 5};           send_pair(c);
    c = '{0, 0, 0, 0, 0, 0, 0, 0};             send_pair(c);
    c = '{-5, 5, 5, -5, -5, -5, 5, 5};         send_pair(c);
    c = '{1, 0, 9, 0, 0, -1, 10, 1};           send_pair(c);
    c = '{-1, 1, 9, 1, 0, -1, 10, 1};          send_pair(c);

    // Random pairs. Most are built around a shared point or a shared line so
    // that they get past the rejections; the rest are unconstrained.
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS - 60) calm = 1'b1;
      mode = $urandom_range(0, 2);
      kind = $urandom_range(0, 9);
      foreach (c[j]) c[j] = rnd_coord(mode);
      if (kind < 4) begin
        // Q passes through the centre of P, so most give cross.
        c[4] = (c[0] >>> 1) + (c[2] >>> 1) - (c[6] - (c[0] >>> 1) - (c[2] >>> 1));
        c[5] = (c[1] >>> 1) + (c[3] >>> 1) - (c[7] - (c[1] >>> 1) - (c[3] >>> 1));
      end else if (kind == 4) begin
        c[4] = c[2]; c[5] = c[3];               // touch at P2
      end else if (kind == 5) begin
        c[6] = c[0]; c[7] = c[1];               // meeting at the open start
      end else if (kind == 6) begin
        k = rnd_coord(1);                       // all four on one line
        c[1] = c[0] * k; c[3] = c[2] * k; c[5] = c[4] * k; c[7] = c[6] * k;
      end
      send_pair(c);
    end
    in_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (board.fails == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== segment_intersection_classifier.f =====
rtl/sic_pkg.sv
rtl/sic_div_stage.sv
rtl/segment_intersection_classifier.sv
tb/tb_segment_intersection_classifier.sv
